// ===== design/ipfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ipfr_pkg
// Shared types and constants for the IP fragment reassembly checker.
// ----------------------------------------------------------------------------
package ipfr_pkg;

    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned FRAG_W       = 33;   // {offset, more_frags, length}
    localparam int unsigned EXP_W        = 18;

    localparam logic [2:0] STS_COMPLETE     = 3'd0;
    localparam logic [2:0] STS_MISMATCH     = 3'd1;
    localparam logic [2:0] STS_MISSING      = 3'd2;
    localparam logic [2:0] STS_INCONSISTENT = 3'd3;
    localparam logic [2:0] STS_DUPLICATE    = 3'd4;
    localparam logic [2:0] STS_INVALID      = 3'd5;
    localparam logic [2:0] STS_FULL         = 3'd6;
    localparam logic [2:0] STS_EMPTY        = 3'd7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DREAD,
        S_DCMP,
        S_STORE,
        S_RPT,
        S_OUT
    } t_state;

endpackage

// ===== design/ip_fragment_reassembly_checker.sv =====
// ----------------------------------------------------------------------------
// ip_fragment_reassembly_checker
// Tracks IP fragments per datagram and reports duplicates and reassembly status.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one word per insert or report command.
// The block takes one word at a time; o_stall is high from acceptance until
// the word is done and its last result, if any, has been taken.
// Insert: a sequencer walks the datagram table one key per cycle, then walks
// the stored fragments of the datagram through the single fragment memory
// read port, a read state and a compare state per fragment, then writes the
// fragment. A clean insert gives no result; invalid address, duplicate and
// full give one.
// Report: one result per tracked datagram in insertion order, each formed
// in S_RPT and held in S_OUT until taken; an empty table gives one result.
// Output channel (o_valid / i_stall): the result sits in an output register
// and holds while i_stall is high; the sequencer waits on it.
// Reset empties the table at once (the entry count is cleared); the stores
// themselves keep their contents and are only read below the fill counts.
module ip_fragment_reassembly_checker #(
    parameter int unsigned NUM_DATAGRAMS      = 16,
    parameter int unsigned FRAGS_PER_DATAGRAM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_source_ip,
    input  logic [15:0] i_datagram_id,
    input  logic [15:0] i_frag_offset,
    input  logic        i_more_frags,
    input  logic [15:0] i_frag_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_report_ip,
    output logic [15:0] o_report_id,
    output logic [2:0]  o_status,
    output logic        o_last_result
);
    import ipfr_pkg::*;

    localparam int unsigned N     = NUM_DATAGRAMS;
    localparam int unsigned F     = FRAGS_PER_DATAGRAM;
    localparam int unsigned IW    = (N > 1) ? $clog2(N) : 1;
    localparam int unsigned CW    = $clog2(N + 1);
    localparam int unsigned FIW   = (F > 1) ? $clog2(F) : 1;
    localparam int unsigned FCW   = $clog2(F + 1);
    localparam int unsigned AW    = (N * F > 1) ? $clog2(N * F) : 1;
    localparam int unsigned SUM_W = 17 + $clog2(F + 1);
    localparam int unsigned CMP_W = (SUM_W > EXP_W) ? SUM_W : EXP_W;

    t_state r_state, n_state;

    // latched command
    logic        r_op;
    logic [31:0] r_ip;
    logic [15:0] r_id;
    logic [15:0] r_off;
    logic        r_mf;
    logic [15:0] r_len;

    logic [CW-1:0]  r_num, n_num;
    logic [IW-1:0]  r_idx, n_idx;
    logic [IW-1:0]  r_slot, n_slot;
    logic [FIW-1:0] r_f, n_f;
    logic [FCW-1:0] r_fcnt, n_fcnt;

    // datagram table
    logic [31:0]             r_ip_tab   [N];
    logic [15:0]             r_id_tab   [N];
    logic [FCW-1:0]          r_cnt_tab  [N];
    logic signed [SUM_W-1:0] r_sum_tab  [N];
    logic signed [EXP_W-1:0] r_exp_tab  [N];
    logic                    r_inc_tab  [N];

    // fragment memory
    logic [FRAG_W-1:0] r_frag_mem [N * F];
    logic [FRAG_W-1:0] r_rd;

    logic              ent_init, ent_upd, mem_we;
    logic [AW-1:0]     mem_raddr, mem_waddr;
    logic [FRAG_W-1:0] w_packed;

    logic        r_o_valid, n_o_valid;
    logic [31:0] r_o_ip, n_o_ip;
    logic [15:0] r_o_id, n_o_id;
    logic [2:0]  r_o_status, n_o_status;
    logic        r_o_last, n_o_last;

    logic signed [SUM_W-1:0] w_dlen;
    logic signed [EXP_W-1:0] w_exp_new;
    logic                    w_inc_new;
    logic signed [SUM_W-1:0] w_sum_new;
    logic signed [CMP_W-1:0] w_cmp_sum, w_cmp_exp;
    logic [2:0]              w_rpt_sts;
    logic                    w_idx_last;

    assign w_packed  = {r_off, r_mf, r_len};
    assign w_dlen    = SUM_W'($signed({1'b0, r_len})) - SUM_W'(HEADER_BYTES);
    assign w_exp_new = $signed(EXP_W'({2'b00, r_off}) + EXP_W'({2'b00, r_len})
                       - EXP_W'(HEADER_BYTES));
    assign w_inc_new = r_inc_tab[r_slot] | (!r_mf && (r_off == 16'd0));
    assign w_sum_new = w_inc_new ? r_sum_tab[r_slot] : r_sum_tab[r_slot] + w_dlen;

    assign mem_raddr = AW'(r_slot) * AW'(F) + AW'(r_f);
    assign mem_waddr = AW'(r_slot) * AW'(F) + AW'(r_fcnt[FIW-1:0]);

    assign w_cmp_sum  = CMP_W'(r_sum_tab[r_idx]);
    assign w_cmp_exp  = CMP_W'(r_exp_tab[r_idx]);
    assign w_idx_last = (CW'(r_idx) + CW'(1)) == r_num;

    always_comb begin
        if (r_inc_tab[r_idx]) begin
            w_rpt_sts = STS_INCONSISTENT;
        end else if (w_cmp_sum == w_cmp_exp) begin
            w_rpt_sts = STS_COMPLETE;
        end else if (w_cmp_sum > w_cmp_exp) begin
            w_rpt_sts = STS_MISMATCH;
        end else begin
            w_rpt_sts = STS_MISSING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_num     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_num     <= n_num;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_slot     <= n_slot;
        r_f        <= n_f;
        r_fcnt     <= n_fcnt;
        r_o_ip     <= n_o_ip;
        r_o_id     <= n_o_id;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
        if (r_state == S_IDLE && i_valid) begin
            r_op  <= i_opcode;
            r_ip  <= i_source_ip;
            r_id  <= i_datagram_id;
            r_off <= i_frag_offset;
            r_mf  <= i_more_frags;
            r_len <= i_frag_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_init) begin
            r_ip_tab[r_num[IW-1:0]]  <= r_ip;
            r_id_tab[r_num[IW-1:0]]  <= r_id;
            r_cnt_tab[r_num[IW-1:0]] <= '0;
            r_sum_tab[r_num[IW-1:0]] <= '0;
            r_exp_tab[r_num[IW-1:0]] <= '0;
            r_inc_tab[r_num[IW-1:0]] <= 1'b0;
        end
        if (ent_upd) begin
            r_cnt_tab[r_slot] <= r_fcnt + FCW'(1);
            r_sum_tab[r_slot] <= w_sum_new;
            r_inc_tab[r_slot] <= w_inc_new;
            if (!r_mf) begin
                r_exp_tab[r_slot] <= w_exp_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frag_mem[mem_waddr] <= w_packed;
        end
        r_rd <= r_frag_mem[mem_raddr];
    end

    always_comb begin
        n_state    = r_state;
        n_num      = r_num;
        n_idx      = r_idx;
        n_slot     = r_slot;
        n_f        = r_f;
        n_fcnt     = r_fcnt;
        n_o_valid  = r_o_valid;
        n_o_ip     = r_o_ip;
        n_o_id     = r_o_id;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        ent_init   = 1'b0;
        ent_upd    = 1'b0;
        mem_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_valid) begin
                    if (i_opcode == OP_REPORT) begin
                        if (r_num == '0) begin
                            n_o_valid  = 1'b1;
                            n_o_ip     = '0;
                            n_o_id     = '0;
                            n_o_status = STS_EMPTY;
                            n_o_last   = 1'b1;
                            n_state    = S_OUT;
                        end else begin
                            n_state = S_RPT;
                        end
                    end else if (i_source_ip == 32'd0) begin
                        n_o_valid  = 1'b1;
                        n_o_ip     = '0;
                        n_o_id     = i_datagram_id;
                        n_o_status = STS_INVALID;
                        n_o_last   = 1'b1;
                        n_state    = S_OUT;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (CW'(r_idx) < r_num && r_ip_tab[r_idx] == r_ip
                        && r_id_tab[r_idx] == r_id) begin
                    n_slot = r_idx;
                    n_fcnt = r_cnt_tab[r_idx];
                    n_f    = '0;
                    n_state = (r_cnt_tab[r_idx] == '0) ? S_STORE : S_DREAD;
                end else if (CW'(r_idx) < r_num && !w_idx_last) begin
                    n_idx = r_idx + IW'(1);
                end else if (r_num == CW'(N)) begin
                    n_o_valid  = 1'b1;
                    n_o_ip     = r_ip;
                    n_o_id     = r_id;
                    n_o_status = STS_FULL;
                    n_o_last   = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    // open a new datagram in the next free entry
                    ent_init = 1'b1;
                    n_slot   = r_num[IW-1:0];
                    n_num    = r_num + CW'(1);
                    n_fcnt   = '0;
                    n_state  = S_STORE;
                end
            end
            S_DREAD: begin
                n_state = S_DCMP;
            end
            S_DCMP: begin
                if (r_rd == w_packed) begin
                    n_o_valid  = 1'b1;
                    n_o_ip     = r_ip;
                    n_o_id     = r_id;
                    n_o_status = STS_DUPLICATE;
                    n_o_last   = 1'b1;
                    n_state    = S_OUT;
                end else if ((FCW'(r_f) + FCW'(1)) == r_fcnt) begin
                    n_state = S_STORE;
                end else begin
                    n_f     = r_f + FIW'(1);
                    n_state = S_DREAD;
                end
            end
            S_STORE: begin
                if (r_fcnt >= FCW'(F)) begin
                    n_o_valid  = 1'b1;
                    n_o_ip     = r_ip;
                    n_o_id     = r_id;
                    n_o_status = STS_FULL;
                    n_o_last   = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    mem_we  = 1'b1;
                    ent_upd = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RPT: begin
                n_o_valid  = 1'b1;
                n_o_ip     = r_ip_tab[r_idx];
                n_o_id     = r_id_tab[r_idx];
                n_o_status = w_rpt_sts;
                n_o_last   = w_idx_last;
                n_state    = S_OUT;
            end
            S_OUT: begin
                // hold the word until the receiver takes it
                if (!i_stall) begin
                    n_o_valid = 1'b0;
                    if (r_o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_RPT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_report_ip   = r_o_ip;
    assign o_report_id   = r_o_id;
    assign o_status      = r_o_status;
    assign o_last_result = r_o_last;

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT)
        else $error("result valid outside output state");

    a_num_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num <= CW'(N))
        else $error("entry count above table depth");

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_fcnt < FCW'(F)) && (CW'(r_slot) < r_num))
        else $error("fragment write without room or outside table");

    a_rpt_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RPT |-> r_op == OP_REPORT)
        else $error("report walk on insert command");

endmodule
